>>> rtl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared sizes, request codes, payload types and an index helper for the
// double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

	localparam int DEPTH  = 1024;
	localparam int DATA_W = 32;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int REQ_W  = 3;

	localparam logic [REQ_W-1:0] REQ_QUERY      = 3'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd1;
	localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd4;

	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [DATA_W-1:0] push_value;
	} req_t;

	typedef struct packed {
		logic              popped_valid;
		logic [DATA_W-1:0] popped_value;
		logic              ends_valid;
		logic [DATA_W-1:0] front_value;
		logic [DATA_W-1:0] back_value;
		logic [CNT_W-1:0]  entry_count;
		logic              is_empty;
		logic              push_dropped;
	} res_t;

	// Circular index add; both operands stay below DEPTH.
	function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
			input logic [ADDR_W-1:0] off);
		logic [ADDR_W:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= (ADDR_W + 1)'(DEPTH)) begin
			sum = sum - (ADDR_W + 1)'(DEPTH);
		end
		return sum[ADDR_W-1:0];
	endfunction

endpackage

>>> rtl/dq_ram.sv
// ----------------------------------------------------------------------------
// dq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Bounded deque of words held in a circular buffer with cached end words.
// ----------------------------------------------------------------------------
// A request is taken on any rising edge with start high; busy never rises, so
// a new request may follow in every cycle. Each request gives exactly one
// result, shown for one cycle with done high in the cycle straight after the
// request was taken; the receiver must take it then, as nothing holds it.
// The word store has a registered read port; the front and back words
// are kept in registers, and only a pop has to fetch the word that
// becomes the new end, which arrives from the RAM in the result cycle
// and is forwarded to any request taken in that same cycle.
// A push on a full deque stores nothing and sets push_dropped; a pop on an
// empty deque returns popped_valid low and a zero word. Codes 5 to 7 act as
// a query. The word store needs no clearing after reset.
module double_ended_queue_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  dq_pkg::req_t  req,
	output logic          done,
	output dq_pkg::res_t  result
);

	// Pointer state and cached end words (state after the last request).
	logic [dq_pkg::ADDR_W-1:0] head_q;
	logic [dq_pkg::CNT_W-1:0]  count_q;
	logic [dq_pkg::DATA_W-1:0] front_q;
	logic [dq_pkg::DATA_W-1:0] back_q;

	// Set when the RAM read data holds the true front or back word.
	logic fix_front_s1;
	logic fix_back_s1;

	// Result of the request taken last cycle.
	logic                      done_s1;
	logic                      popped_valid_s1;
	logic [dq_pkg::DATA_W-1:0] popped_value_s1;
	logic                      push_dropped_s1;

	logic                      accept;
	logic                      full;
	logic                      empty;
	logic [dq_pkg::DATA_W-1:0] rdata;
	logic [dq_pkg::DATA_W-1:0] front_cur;
	logic [dq_pkg::DATA_W-1:0] back_cur;

	logic [dq_pkg::ADDR_W-1:0] head_nxt;
	logic [dq_pkg::CNT_W-1:0]  count_nxt;
	logic [dq_pkg::DATA_W-1:0] front_nxt;
	logic [dq_pkg::DATA_W-1:0] back_nxt;
	logic                      fix_front_nxt;
	logic                      fix_back_nxt;
	logic                      popped_valid_nxt;
	logic [dq_pkg::DATA_W-1:0] popped_value_nxt;
	logic                      push_dropped_nxt;

	logic                      we;
	logic [dq_pkg::ADDR_W-1:0] waddr;
	logic [dq_pkg::ADDR_W-1:0] raddr;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (count_q == dq_pkg::CNT_W'(dq_pkg::DEPTH));
	assign empty  = (count_q == '0);

	// Forward a freshly fetched end word ahead of the stale cached copy.
	assign front_cur = fix_front_s1 ? rdata : front_q;
	assign back_cur  = fix_back_s1  ? rdata : back_q;

	always_comb begin
		head_nxt         = head_q;
		count_nxt        = count_q;
		front_nxt        = front_cur;
		back_nxt         = back_cur;
		fix_front_nxt    = 1'b0;
		fix_back_nxt     = 1'b0;
		popped_valid_nxt = 1'b0;
		popped_value_nxt = '0;
		push_dropped_nxt = 1'b0;
		we               = 1'b0;
		waddr            = head_q;
		raddr            = head_q;
		if (accept) begin
			case (req.req_type)
				dq_pkg::REQ_PUSH_FRONT: begin
					if (full) begin
						push_dropped_nxt = 1'b1;
					end else begin
						// Step the head back and drop the word in front of it.
						head_nxt  = dq_pkg::wrap_add(head_q,
							dq_pkg::ADDR_W'(dq_pkg::DEPTH - 1));
						waddr     = head_nxt;
						we        = 1'b1;
						count_nxt = count_q + 1'b1;
						front_nxt = req.push_value;
						if (empty) begin
							back_nxt = req.push_value;
						end
					end
				end
				dq_pkg::REQ_PUSH_BACK: begin
					if (full) begin
						push_dropped_nxt = 1'b1;
					end else begin
						waddr     = dq_pkg::wrap_add(head_q, count_q[dq_pkg::ADDR_W-1:0]);
						we        = 1'b1;
						count_nxt = count_q + 1'b1;
						back_nxt  = req.push_value;
						if (empty) begin
							front_nxt = req.push_value;
						end
					end
				end
				dq_pkg::REQ_POP_FRONT: begin
					if (!empty) begin
						popped_valid_nxt = 1'b1;
						popped_value_nxt = front_cur;
						head_nxt         = dq_pkg::wrap_add(head_q, dq_pkg::ADDR_W'(1));
						count_nxt        = count_q - 1'b1;
						// Fetch the word behind the old front.
						raddr            = head_nxt;
						fix_front_nxt    = (count_nxt != '0);
					end
				end
				dq_pkg::REQ_POP_BACK: begin
					if (!empty) begin
						popped_valid_nxt = 1'b1;
						popped_value_nxt = back_cur;
						count_nxt        = count_q - 1'b1;
						// Fetch the word before the old back.
						raddr            = dq_pkg::wrap_add(head_q,
							dq_pkg::ADDR_W'(count_q - dq_pkg::CNT_W'(2)));
						fix_back_nxt     = (count_nxt != '0);
					end
				end
				default: begin
					// Query and unused codes: hold everything.
				end
			endcase
		end
	end

	dq_ram #(
		.WIDTH(dq_pkg::DATA_W),
		.DEPTH(dq_pkg::DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(req.push_value),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			count_q      <= '0;
			fix_front_s1 <= 1'b0;
			fix_back_s1  <= 1'b0;
			done_s1      <= 1'b0;
		end else begin
			head_q       <= head_nxt;
			count_q      <= count_nxt;
			fix_front_s1 <= fix_front_nxt;
			fix_back_s1  <= fix_back_nxt;
			done_s1      <= accept;
		end
	end

	// Cached ends and result payload carry no reset.
	always_ff @(posedge clk) begin
		front_q         <= front_nxt;
		back_q          <= back_nxt;
		popped_valid_s1 <= popped_valid_nxt;
		popped_value_s1 <= popped_value_nxt;
		push_dropped_s1 <= push_dropped_nxt;
	end

	// Count and ends come straight from the state left by the last request.
	assign done                = done_s1;
	assign result.popped_valid = popped_valid_s1;
	assign result.popped_value = popped_value_s1;
	assign result.ends_valid   = !empty;
	assign result.front_value  = empty ? '0 : front_cur;
	assign result.back_value   = empty ? '0 : back_cur;
	assign result.entry_count  = count_q;
	assign result.is_empty     = empty;
	assign result.push_dropped = push_dropped_s1;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= dq_pkg::CNT_W'(dq_pkg::DEPTH))
		else $error("stored count beyond depth");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("request without result");

	a_no_stray_result: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> !done)
		else $error("result without request");

	a_pop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !empty && (req.req_type == dq_pkg::REQ_POP_FRONT ||
			req.req_type == dq_pkg::REQ_POP_BACK))
		|=> (count_q == $past(count_q) - 1'b1) && result.popped_valid)
		else $error("pop did not remove a word");

	a_drop_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.push_dropped) |-> (full && $stable(count_q)))
		else $error("push dropped while space remained");
`endif

endmodule

>>> tb/double_ended_queue_checker.sv
// ----------------------------------------------------------------------------
// double_ended_queue_checker
// Watches the request and result channels of the deque, keeps a shadow copy
// of its contents and compares every result with the predicted one.
// ----------------------------------------------------------------------------
module double_ended_queue_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic         busy,
	input  dq_pkg::req_t req,
	input  logic         done,
	input  dq_pkg::res_t result,
	output int           errors,
	output int           pending
);

	timeunit 1ns;
	timeprecision 1ps;

	logic [dq_pkg::DATA_W-1:0] shadow_words [dq_pkg::DEPTH];
	logic [dq_pkg::ADDR_W-1:0] shadow_head;
	logic [dq_pkg::CNT_W-1:0]  shadow_count;
	dq_pkg::res_t              owed_results [$];
	dq_pkg::res_t              want;

	function automatic logic [dq_pkg::ADDR_W-1:0] ring_pos(input int base, input int off);
		return dq_pkg::ADDR_W'((base + off) % dq_pkg::DEPTH);
	endfunction

	// Apply one request to the shadow deque and build the result it earns.
	function automatic dq_pkg::res_t apply_request(input dq_pkg::req_t r);
		dq_pkg::res_t o;
		o = '0;
		case (r.req_type)
			dq_pkg::REQ_PUSH_FRONT: begin
				if (shadow_count == dq_pkg::CNT_W'(dq_pkg::DEPTH)) begin
					o.push_dropped = 1'b1;
				end else begin
					shadow_head = ring_pos(shadow_head, dq_pkg::DEPTH - 1);
					shadow_words[shadow_head] = r.push_value;
					shadow_count++;
				end
			end
			dq_pkg::REQ_PUSH_BACK: begin
				if (shadow_count == dq_pkg::CNT_W'(dq_pkg::DEPTH)) begin
					o.push_dropped = 1'b1;
				end else begin
					shadow_words[ring_pos(shadow_head, shadow_count)] = r.push_value;
					shadow_count++;
				end
			end
			dq_pkg::REQ_POP_FRONT: begin
				if (shadow_count != '0) begin
					o.popped_valid = 1'b1;
					o.popped_value = shadow_words[shadow_head];
					shadow_head = ring_pos(shadow_head, 1);
					shadow_count--;
				end
			end
			dq_pkg::REQ_POP_BACK: begin
				if (shadow_count != '0) begin
					o.popped_valid = 1'b1;
					o.popped_value = shadow_words[ring_pos(shadow_head, shadow_count - 1)];
					shadow_count--;
				end
			end
			default: begin
			end
		endcase
		o.entry_count = shadow_count;
		o.is_empty    = (shadow_count == '0);
		o.ends_valid  = (shadow_count != '0);
		if (o.ends_valid) begin
			o.front_value = shadow_words[shadow_head];
			o.back_value  = shadow_words[ring_pos(shadow_head, shadow_count - 1)];
		end
		return o;
	endfunction

	task automatic check_field(input string field, input logic [63:0] exp_val,
			input logic [63:0] act_val);
		if (act_val !== exp_val) begin
			$display("%0t: %s expected 0x%0h, actual 0x%0h", $time, field, exp_val, act_val);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_head  = '0;
			shadow_count = '0;
			owed_results.delete();
			errors = 0;
			pending <= 0;
		end else begin
			// a result is due in the cycle after its request, so check before predicting
			if (done) begin
				if (owed_results.size() == 0) begin
					$display("%0t: result with no request outstanding, actual %p", $time, result);
					errors++;
				end else begin
					want = owed_results[0];
					owed_results.delete(0);
					check_field("popped_valid", want.popped_valid, result.popped_valid);
					check_field("popped_value", want.popped_value, result.popped_value);
					check_field("ends_valid", want.ends_valid, result.ends_valid);
					check_field("front_value", want.front_value, result.front_value);
					check_field("back_value", want.back_value, result.back_value);
					check_field("entry_count", want.entry_count, result.entry_count);
					check_field("is_empty", want.is_empty, result.is_empty);
					check_field("push_dropped", want.push_dropped, result.push_dropped);
				end
			end
			if (start && !busy) begin
				owed_results.insert(owed_results.size(), apply_request(req));
			end
			pending <= owed_results.size();
		end
	end

endmodule

>>> tb/double_ended_queue_top_tb.sv
// ----------------------------------------------------------------------------
// double_ended_queue_top_tb
// Drives requests into the deque: a directed set around the empty and wrap
// cases, then random traffic that builds it up deeply and drains it again.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module double_ended_queue_top_tb;

	timeunit 1ns;
	timeprecision 1ps;

	// Codes the block does not use; they must behave as a query.
	localparam logic [dq_pkg::REQ_W-1:0] REQ_SPARE_A = 3'd5;
	localparam logic [dq_pkg::REQ_W-1:0] REQ_SPARE_B = 3'd6;
	localparam logic [dq_pkg::REQ_W-1:0] REQ_SPARE_C = 3'd7;

	typedef enum {MIX_EVEN, MIX_FILL, MIX_DRAIN} mix_t;

	logic         clk    = 1'b0;
	logic         arst_n = 1'b0;
	logic         start  = 1'b0;
	logic         busy;
	dq_pkg::req_t req    = '0;
	logic         done;
	dq_pkg::res_t result;
	int           errors;
	int           pending;

	// Rough occupancy, kept only to steer the traffic.
	int   fill     = 0;
	int   idle_pct = 0;

	double_ended_queue_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.result (result)
	);

	double_ended_queue_checker checker_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.req     (req),
		.done    (done),
		.result  (result),
		.errors  (errors),
		.pending (pending)
	);

	always #6 clk = ~clk;

	// Mostly random words, with the all-zero and all-one patterns mixed in.
	function automatic logic [dq_pkg::DATA_W-1:0] pick_word();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return dq_pkg::DATA_W'($urandom);
		endcase
	endfunction

	// Choose a request code; the mix tilts the traffic towards filling or draining.
	function automatic logic [dq_pkg::REQ_W-1:0] pick_code(input mix_t mix);
		int unsigned roll;
		int unsigned push_share;
		int unsigned pop_share;
		roll = $urandom_range(99);
		case (mix)
			MIX_FILL: begin
				push_share = 90;
				pop_share  = 6;
			end
			MIX_DRAIN: begin
				push_share = 6;
				pop_share  = 90;
			end
			default: begin
				push_share = 40;
				pop_share  = 40;
			end
		endcase
		if (roll < push_share) begin
			return $urandom_range(1) ? dq_pkg::REQ_PUSH_FRONT : dq_pkg::REQ_PUSH_BACK;
		end
		if (roll < push_share + pop_share) begin
			return $urandom_range(1) ? dq_pkg::REQ_POP_FRONT : dq_pkg::REQ_POP_BACK;
		end
		case ($urandom_range(3))
			0: return REQ_SPARE_A;
			1: return REQ_SPARE_B;
			2: return REQ_SPARE_C;
			default: return dq_pkg::REQ_QUERY;
		endcase
	endfunction

	// Send one request: idle at random first, then hold start until it is taken.
	task automatic issue(input logic [dq_pkg::REQ_W-1:0] code,
			input logic [dq_pkg::DATA_W-1:0] word);
		dq_pkg::req_t r;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			// scramble the payload while idle; the block must ignore it
			req   <= {dq_pkg::REQ_W'($urandom), dq_pkg::DATA_W'($urandom)};
			@(posedge clk);
		end
		r.req_type   = code;
		r.push_value = word;
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		case (code)
			dq_pkg::REQ_PUSH_FRONT, dq_pkg::REQ_PUSH_BACK: if (fill < dq_pkg::DEPTH) fill++;
			dq_pkg::REQ_POP_FRONT, dq_pkg::REQ_POP_BACK:   if (fill > 0) fill--;
			default: begin
			end
		endcase
	endtask

	task automatic run_mix(input mix_t mix, input int n);
		repeat (n) begin
			issue(pick_code(mix), pick_word());
		end
	endtask

	// Drop start and hold off until every outstanding result has come back.
	task automatic hold_until_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
	endtask

	// Hard stop in case the block hangs.
	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: pops and query on an empty deque.
		issue(dq_pkg::REQ_POP_FRONT, 32'hDEAD_BEEF);
		issue(dq_pkg::REQ_POP_BACK, 32'h1234_5678);
		issue(dq_pkg::REQ_QUERY, '1);
		// Extreme words at both ends; the first front push wraps the head below zero.
		issue(dq_pkg::REQ_PUSH_FRONT, 32'hFFFF_FFFF);
		issue(dq_pkg::REQ_PUSH_BACK, 32'h0000_0000);
		issue(dq_pkg::REQ_PUSH_FRONT, 32'h8000_0001);
		issue(dq_pkg::REQ_PUSH_BACK, 32'h7FFF_FFFE);
		issue(dq_pkg::REQ_QUERY, 32'hAAAA_5555);
		// Unused codes with a live payload must change nothing.
		issue(REQ_SPARE_A, 32'h5555_AAAA);
		issue(REQ_SPARE_B, '1);
		issue(REQ_SPARE_C, 32'h0F0F_F0F0);
		// Empty it from alternate ends, then pop once more on empty.
		issue(dq_pkg::REQ_POP_FRONT, '0);
		issue(dq_pkg::REQ_POP_BACK, '0);
		issue(dq_pkg::REQ_POP_FRONT, '0);
		issue(dq_pkg::REQ_POP_BACK, '0);
		issue(dq_pkg::REQ_POP_FRONT, '0);
		// Single-entry cases: push at one end, pop at the other.
		issue(dq_pkg::REQ_PUSH_FRONT, 32'hC001_D00D);
		issue(dq_pkg::REQ_POP_BACK, '0);
		issue(dq_pkg::REQ_PUSH_BACK, 32'h0BAD_F00D);
		issue(dq_pkg::REQ_POP_FRONT, '0);
		// Back-to-back front pushes then front pops.
		issue(dq_pkg::REQ_PUSH_FRONT, 32'h0000_0001);
		issue(dq_pkg::REQ_PUSH_FRONT, 32'h8000_0000);
		issue(dq_pkg::REQ_POP_FRONT, '0);
		issue(dq_pkg::REQ_POP_FRONT, '0);
		hold_until_drained();

		// Phase one: sender idles about a fifth of the time, even mix.
		idle_pct = 22;
		run_mix(MIX_EVEN, 150);
		run_mix(MIX_FILL, 60);
		run_mix(MIX_EVEN, 90);
		hold_until_drained();

		// Phase two: sender idles over half the time; build the deque up,
		// then drain past empty.
		idle_pct = 55;
		run_mix(MIX_FILL, 100);
		while (fill > 0) begin
			issue(pick_code(MIX_DRAIN), pick_word());
		end
		run_mix(MIX_DRAIN, 10);
		hold_until_drained();

		// Phase three: no idling at all, back-to-back requests.
		idle_pct = 0;
		run_mix(MIX_EVEN, 80);
		hold_until_drained();
		run_mix(MIX_FILL, 50);
		run_mix(MIX_EVEN, 50);
		run_mix(MIX_DRAIN, 50);

		// Wait for the last results, then give stray ones a chance to show.
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);

		if (errors == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
